/* rtl/mesh_edge_table_builder_defines.svh */
// Assertion helpers used by the checker file.
`ifndef MESH_EDGE_TABLE_BUILDER_DEFINES_SVH
`define MESH_EDGE_TABLE_BUILDER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define METB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define METB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/metb_pkg.sv */
package metb_pkg;

    localparam int MAX_EDGES_DEF     = 1024;
    localparam int VERTEX_BITS_DEF   = 16;
    localparam int TRIANGLE_BITS_DEF = 16;

    // Fixed field widths on the stream ports
    localparam int VERTEX_W    = 16;
    localparam int TRI_OUT_W   = 16;
    localparam int INDEX_W     = 10;
    localparam int NB_W        = 16;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_FIELD_W = TRI_OUT_W + 3 * INDEX_W + 3 + 3 * NB_W;

    // Edge being handled within a triangle
    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_CA = 2'd2;

    typedef struct packed {
        logic load;        // capture request, start a triangle
        logic edge_start;  // set up the vertex pair of the current edge
        logic issue;       // read the next table entry
        logic take_hit;    // record a match on the pending read
        logic take_miss;   // append the edge or flag overflow
        logic publish;     // load the result register
    } metb_cmd_t;

    typedef struct packed {
        logic hit;          // pending read matches the current edge
        logic cmp_pending;  // a read is in flight
        logic issue_done;   // every stored entry has been read
        logic last_edge;    // current edge is c-a
        logic out_busy;     // result register held by the sink
    } metb_status_t;

endpackage

/* rtl/metb_ram.sv */
module metb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/metb_ctrl.sv */
module metb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  metb_pkg::metb_status_t status,
    output metb_pkg::metb_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EDGE = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                cmd.edge_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                if (status.hit)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = status.last_edge ? S_DONE : S_EDGE;
                end
                else if (!status.cmp_pending && status.issue_done)
                begin
                    cmd.take_miss = 1'b1;
                    state_next    = status.last_edge ? S_DONE : S_EDGE;
                end
                else if (!status.issue_done)
                begin
                    cmd.issue = 1'b1;
                end
            end
            S_DONE:
            begin
                // hold until the result register is free
                if (!status.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/metb_datapath.sv */
module metb_datapath #(
    parameter int MAX_EDGES     = metb_pkg::MAX_EDGES_DEF,
    parameter int VERTEX_BITS   = metb_pkg::VERTEX_BITS_DEF,
    parameter int TRIANGLE_BITS = metb_pkg::TRIANGLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  metb_pkg::metb_cmd_t                 cmd,
    output metb_pkg::metb_status_t              status,
    input  logic [metb_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [metb_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tuser
);

    localparam int ADDR_W  = $clog2(MAX_EDGES);
    localparam int CNT_W   = $clog2(MAX_EDGES + 1);
    localparam int ENTRY_W = 2 * VERTEX_BITS + TRIANGLE_BITS;
    localparam int VW      = metb_pkg::VERTEX_W;

    // Triangle capture
    logic [VERTEX_BITS-1:0]   va_reg, vb_reg, vc_reg;
    logic [TRIANGLE_BITS-1:0] tri_reg;
    logic [TRIANGLE_BITS-1:0] tri_count_reg;
    logic [TRIANGLE_BITS-1:0] tri_cur;
    logic [31:0]              va_w, vb_w, vc_w;

    // Table walk
    logic [CNT_W-1:0]         edge_count_reg;
    logic [1:0]               edge_sel_reg;
    logic [VERTEX_BITS-1:0]   lo_reg, hi_reg;
    logic [VERTEX_BITS-1:0]   vp, vq, lo_next, hi_next;
    logic [CNT_W-1:0]         rd_addr_reg;
    logic                     cmp_pending_reg;
    logic [ADDR_W-1:0]        cmp_addr_reg;
    logic                     table_full;
    logic [ENTRY_W-1:0]       rd_data;
    logic                     wr_en;

    // Per-edge results
    logic [ADDR_W-1:0]        idx_reg [3];
    logic [2:0]               shared_reg;
    logic [TRIANGLE_BITS-1:0] nb_reg [3];
    logic                     ovf_reg;

    // Result register
    logic                     out_valid_reg;
    logic [metb_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic                     out_user_reg;
    logic [31:0]              tri_w;
    logic [31:0]              idx_w [3];
    logic [31:0]              nb_w [3];

    assign va_w = 32'(s_tdata[VW-1:0]);
    assign vb_w = 32'(s_tdata[2*VW-1:VW]);
    assign vc_w = 32'(s_tdata[3*VW-1:2*VW]);

    assign tri_cur = s_tuser ? '0 : tri_count_reg;

    always_comb
    begin
        case (edge_sel_reg)
            metb_pkg::EDGE_AB:
            begin
                vp = va_reg;
                vq = vb_reg;
            end
            metb_pkg::EDGE_BC:
            begin
                vp = vb_reg;
                vq = vc_reg;
            end
            default:
            begin
                vp = vc_reg;
                vq = va_reg;
            end
        endcase
        lo_next = (vp < vq) ? vp : vq;
        hi_next = (vp < vq) ? vq : vp;
    end

    assign table_full = (edge_count_reg == CNT_W'(MAX_EDGES));
    assign wr_en      = cmd.take_miss && !table_full;

    assign status.hit         = cmp_pending_reg
                                && (rd_data[VERTEX_BITS-1:0] == lo_reg)
                                && (rd_data[2*VERTEX_BITS-1:VERTEX_BITS] == hi_reg);
    assign status.cmp_pending = cmp_pending_reg;
    assign status.issue_done  = (rd_addr_reg == edge_count_reg);
    assign status.last_edge   = (edge_sel_reg == metb_pkg::EDGE_CA);
    assign status.out_busy    = out_valid_reg && !m_tready;

    metb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (edge_count_reg[ADDR_W-1:0]),
        .wr_data ({tri_reg, hi_reg, lo_reg}),
        .rd_en   (cmd.issue),
        .rd_addr (rd_addr_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_count_reg  <= '0;
            tri_count_reg   <= '0;
            edge_sel_reg    <= metb_pkg::EDGE_AB;
            rd_addr_reg     <= '0;
            cmp_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            cmp_pending_reg <= cmd.issue;
            if (cmd.load)
            begin
                tri_count_reg <= tri_cur + 1'b1;
                edge_sel_reg  <= metb_pkg::EDGE_AB;
                if (s_tuser)
                begin
                    edge_count_reg <= '0;
                end
            end
            if (cmd.edge_start)
            begin
                rd_addr_reg <= '0;
            end
            else if (cmd.issue)
            begin
                rd_addr_reg <= rd_addr_reg + 1'b1;
            end
            if (cmd.take_hit || cmd.take_miss)
            begin
                edge_sel_reg <= edge_sel_reg + 1'b1;
            end
            if (wr_en)
            begin
                edge_count_reg <= edge_count_reg + 1'b1;
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            va_reg  <= va_w[VERTEX_BITS-1:0];
            vb_reg  <= vb_w[VERTEX_BITS-1:0];
            vc_reg  <= vc_w[VERTEX_BITS-1:0];
            tri_reg <= tri_cur;
            ovf_reg <= 1'b0;
        end
        if (cmd.edge_start)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (cmd.issue)
        begin
            cmp_addr_reg <= rd_addr_reg[ADDR_W-1:0];
        end
        if (cmd.take_hit)
        begin
            idx_reg[edge_sel_reg]    <= cmp_addr_reg;
            shared_reg[edge_sel_reg] <= 1'b1;
            nb_reg[edge_sel_reg]     <= rd_data[ENTRY_W-1:2*VERTEX_BITS];
        end
        if (cmd.take_miss)
        begin
            shared_reg[edge_sel_reg] <= 1'b0;
            nb_reg[edge_sel_reg]     <= tri_reg;
            if (table_full)
            begin
                // drop the edge
                idx_reg[edge_sel_reg] <= '0;
                ovf_reg               <= 1'b1;
            end
            else
            begin
                idx_reg[edge_sel_reg] <= edge_count_reg[ADDR_W-1:0];
            end
        end
        if (cmd.publish)
        begin
            out_data_reg <= metb_pkg::OUT_TDATA_W'({
                nb_w[2][metb_pkg::NB_W-1:0],
                nb_w[1][metb_pkg::NB_W-1:0],
                nb_w[0][metb_pkg::NB_W-1:0],
                shared_reg[2], shared_reg[1], shared_reg[0],
                idx_w[2][metb_pkg::INDEX_W-1:0],
                idx_w[1][metb_pkg::INDEX_W-1:0],
                idx_w[0][metb_pkg::INDEX_W-1:0],
                tri_w[metb_pkg::TRI_OUT_W-1:0]
            });
            out_user_reg <= ovf_reg;
        end
    end

    assign tri_w = 32'(tri_reg);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            idx_w[i] = 32'(idx_reg[i]);
            nb_w[i]  = 32'(nb_reg[i]);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

/* rtl/mesh_edge_table_builder.sv */
// Triangle mesh edge table. Each request is one triangle; its edges a-b, b-c
// and c-a are looked up in turn in an edge table of MAX_EDGES entries, with
// the vertex pair stored smaller index first. A matching entry reports its
// first owning triangle; a new edge is appended with this triangle as owner,
// or dropped with the overflow flag set when the table is full. new_mesh in
// s_tuser empties the table and restarts triangle numbering at zero for the
// request that carries it. One triangle is handled at a time; for each of
// its edges the vertex pair is set up and the stored entries are read
// in turn. An edge that matches reads the table up to and including its
// match; a new edge reads all stored entries, none on an empty table, before
// it is appended or dropped. The lookup is bounded by the single read port
// of the edge table RAM, through which one stored edge is compared per
// cycle. The next request is taken while a finished result waits on the
// master side. No clearing pass runs after reset; the table is bounded by
// its fill count.
module mesh_edge_table_builder #(
    parameter int MAX_EDGES     = metb_pkg::MAX_EDGES_DEF,
    parameter int VERTEX_BITS   = metb_pkg::VERTEX_BITS_DEF,
    parameter int TRIANGLE_BITS = metb_pkg::TRIANGLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // vertex_a[15:0], vertex_b[31:16], vertex_c[47:32]
    input  logic [metb_pkg::IN_TDATA_W-1:0]  s_tdata,
    // new_mesh[0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // triangle_number_out[15:0], edge_ab_index[25:16], edge_bc_index[35:26],
    // edge_ca_index[45:36], ab_was_shared[46], bc_was_shared[47],
    // ca_was_shared[48], ab_neighbour[64:49], bc_neighbour[80:65],
    // ca_neighbour[96:81], zero fill[103:97]
    output logic [metb_pkg::OUT_TDATA_W-1:0] m_tdata,
    // table_overflow[0]
    output logic                             m_tuser
);

    metb_pkg::metb_cmd_t    cmd;
    metb_pkg::metb_status_t status;

    metb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    metb_datapath #(
        .MAX_EDGES     (MAX_EDGES),
        .VERTEX_BITS   (VERTEX_BITS),
        .TRIANGLE_BITS (TRIANGLE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/metb_checker.sv */
`include "mesh_edge_table_builder_defines.svh"

module metb_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [metb_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic                             s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [metb_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tuser
);

    logic in_fire;

    assign in_fire = s_tvalid && s_tready;

    `METB_ASSERT_NEXT(a_in_hold, clk, rst_n, s_tvalid && !s_tready,
        s_tvalid && $stable(s_tdata) && $stable(s_tuser), "request changed while waiting")

    `METB_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    `METB_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_fire, !s_tready,
        "request taken while a triangle is in work")

    `METB_ASSERT_NOW(a_own_neighbour, clk, rst_n, m_tvalid,
        (m_tdata[46] || m_tdata[64:49] == m_tdata[15:0])
        && (m_tdata[47] || m_tdata[80:65] == m_tdata[15:0])
        && (m_tdata[48] || m_tdata[96:81] == m_tdata[15:0]),
        "unshared edge names another triangle")

    `METB_ASSERT_NOW(a_fill_zero, clk, rst_n, m_tvalid,
        m_tdata[metb_pkg::OUT_TDATA_W-1:metb_pkg::OUT_FIELD_W] == '0,
        "fill bits of result not zero")

endmodule

bind mesh_edge_table_builder metb_checker u_metb_checker (.*);
